[hdl/assert_macros.svh]
// Assertion macros shared by the symbol table modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

[hdl/lpst_pkg.sv]
// Package for the linear probe symbol table: sizes, codes and shared types.
// Used by the controller, datapath and top level.
package lpst_pkg;
   localparam int TableSlots = 1024;
   localparam int NameBytes = 8;
   localparam int KeyW = 64;
   localparam int SlotW = 10;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   localparam logic [2:0] ST_FOUND = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_DELETED = 3'd3;
   localparam logic [2:0] ST_DEL_MISSING = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // capture request and normalize
      logic clr_step;    // advance clearing pass
      logic rd_probe;    // read slot at probe pointer
      logic adv_probe;   // probe pointer + 1
      logic wr_insert;   // write key at probe pointer
      logic start_del;   // hole = probe, scan = probe
      logic rd_scan;     // read slot at scan + 1, scan advances
      logic wr_hole_clr; // clear slot at hole
      logic wr_move;     // copy scanned entry into hole, hole = scan
      logic cnt_inc;
      logic cnt_dec;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clr_done;
      logic rd_used;     // registered read: slot used
      logic rd_match;    // registered read: same key and home
      logic rd_movable;  // scanned entry may move into hole
      logic probe_wrap;  // next probe would return to home
      logic scan_wrap;   // scan returned to hole
      logic is_full;     // count + 1 would reach slots - 1
      logic [1:0] action;
   } sts_type;
endpackage

[hdl/lpst_chan_if.sv]
// Valid/ready channel carrying one payload beat of a chosen type.
// Depends on nothing; payload type is a parameter.
interface lpst_chan_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/lpst_datapath.sv]
// Datapath of the symbol table: slot memory, pointers, key normalization.
// Uses lpst_pkg for command and status types.
module lpst_datapath #(
   parameter int TABLE_SLOTS = lpst_pkg::TableSlots,
   parameter int NAME_BYTES = lpst_pkg::NameBytes,
   localparam int AW = $clog2(TABLE_SLOTS)
) (
   input  logic clock,
   input  logic reset,
   input  lpst_pkg::cmd_type cmd,
   output lpst_pkg::sts_type sts,
   input  logic [1:0] req_action,
   input  logic [lpst_pkg::KeyW-1:0] req_name_key,
   output logic [AW-1:0] probe_slot
);
   localparam int EW = lpst_pkg::KeyW + AW + 1;
   localparam int CW = AW + 1;

   logic [EW-1:0] mem [TABLE_SLOTS];
   logic [EW-1:0] rd_ff;
   logic [lpst_pkg::KeyW-1:0] key_ff, key_in;
   logic [AW-1:0] home_ff, home_in;
   logic [1:0] act_ff;
   logic [AW-1:0] probe_ff, hole_ff, scan_ff, clr_ff;
   logic clr_done_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] scan_nx, probe_nx, rd_addr, wr_addr, rd_home;
   logic [EW-1:0] wr_data;
   logic wr_en, rd_en;

   function automatic logic [AW-1:0] incr(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      r = (v == AW'(TABLE_SLOTS - 1)) ? '0 : v + 1'b1;
      return r;
   endfunction

   // Bytes up to the first zero byte; sum is at most 8*255, 11 bits.
   always_comb begin
      logic stop;
      logic [10:0] sum;
      key_in = '0;
      sum = '0;
      stop = 1'b0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (req_name_key[8*b +: 8] == 8'd0) stop = 1'b1;
         if (!stop) begin
            key_in[8*b +: 8] = req_name_key[8*b +: 8];
            sum = sum + 11'(req_name_key[8*b +: 8]);
         end
      end
      home_in = AW'(32'(sum) % TABLE_SLOTS);
   end

   assign scan_nx = incr(scan_ff);
   assign probe_nx = incr(probe_ff);

   always_comb begin
      rd_en = cmd.rd_probe | cmd.rd_scan;
      rd_addr = cmd.rd_scan ? scan_nx : probe_ff;
      wr_en = cmd.clr_step | cmd.wr_insert | cmd.wr_hole_clr | cmd.wr_move;
      wr_addr = hole_ff;
      wr_data = '0;
      if (cmd.clr_step) wr_addr = clr_ff;
      else if (cmd.wr_insert) begin
         wr_addr = probe_ff;
         wr_data = {1'b1, home_ff, key_ff};
      end else if (cmd.wr_move) wr_data = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_in;
         home_ff <= home_in;
         act_ff <= req_action;
         probe_ff <= home_in;
      end else if (cmd.adv_probe) probe_ff <= probe_nx;
      if (cmd.start_del) begin
         hole_ff <= probe_ff;
         scan_ff <= probe_ff;
      end else begin
         if (cmd.rd_scan) scan_ff <= scan_nx;
         if (cmd.wr_move) hole_ff <= scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= incr(clr_ff);
            if (clr_ff == AW'(TABLE_SLOTS - 1)) clr_done_ff <= 1'b1;
         end
         if (cmd.cnt_inc) count_ff <= count_ff + 1'b1;
         else if (cmd.cnt_dec && count_ff != '0) count_ff <= count_ff - 1'b1;
      end
   end

   assign rd_home = rd_ff[lpst_pkg::KeyW +: AW];

   // Entry at scan with home h may fill the hole unless h lies cyclically in (hole, scan].
   assign sts.rd_movable = !((hole_ff < rd_home && rd_home <= scan_ff) ||
                             (scan_ff < hole_ff && hole_ff < rd_home) ||
                             (rd_home <= scan_ff && scan_ff < hole_ff));

   assign sts.clr_done = clr_done_ff;
   assign sts.rd_used = rd_ff[EW-1];
   assign sts.rd_match = rd_home == home_ff && rd_ff[lpst_pkg::KeyW-1:0] == key_ff;
   assign sts.probe_wrap = probe_nx == home_ff;
   assign sts.scan_wrap = scan_ff == hole_ff;
   assign sts.is_full = (count_ff + 1'b1) >= CW'(TABLE_SLOTS - 1);
   assign sts.action = act_ff;
   assign probe_slot = probe_ff;

   `include "assert_macros.svh"
   `ASSERT_CLK(a_cnt_bound, clock, reset, count_ff <= CW'(TABLE_SLOTS - 1), "count overflow")
   `ASSERT_CLK(a_one_write, clock, reset,
      $countones({cmd.clr_step, cmd.wr_insert, cmd.wr_hole_clr, cmd.wr_move}) <= 1,
      "write conflict")
   `ASSERT_CLK(a_clr_first, clock, reset, !clr_done_ff |-> !cmd.wr_insert, "insert before clear")
endmodule

[hdl/lpst_ctrl.sv]
// Controller state machine for the symbol table: clearing pass, probe, insert, delete shift.
// Uses lpst_pkg command, status and code constants.
module lpst_ctrl #(
   parameter int TABLE_SLOTS = lpst_pkg::TableSlots,
   localparam int AW = $clog2(TABLE_SLOTS)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [9:0] rsp_slot_index,
   input  logic [AW-1:0] probe_slot,
   input  lpst_pkg::sts_type sts,
   output lpst_pkg::cmd_type cmd
);
   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_PRD   = 8'b0000_0100,
      S_PCHK  = 8'b0000_1000,
      S_DCLR  = 8'b0001_0000,
      S_SRD   = 8'b0010_0000,
      S_SCHK  = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;
   logic [9:0] slot_ff, slot_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [9:0] probe10;

   assign probe10 = 10'(probe_slot);
   assign req_ready = state_ff == S_IDLE && !rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in = status_ff;
      slot_in = slot_ff;
      walk_in = walk_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = !sts.clr_done;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1;
            walk_in = '0;
            state_in = S_PRD;
         end
         S_PRD: begin
            cmd.rd_probe = 1'b1;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            slot_in = '0;
            state_in = S_RESP;
            if (sts.rd_used && sts.rd_match) begin
               if (sts.action == lpst_pkg::ACT_DELETE) begin
                  cmd.start_del = 1'b1;
                  cmd.cnt_dec = 1'b1;
                  status_in = lpst_pkg::ST_DELETED;
                  state_in = S_DCLR;
               end else begin
                  status_in = lpst_pkg::ST_FOUND;
                  slot_in = probe10;
               end
            end else if (!sts.rd_used) begin
               if (sts.action == lpst_pkg::ACT_DELETE)
                  status_in = lpst_pkg::ST_DEL_MISSING;
               else if (sts.action == lpst_pkg::ACT_INSERT) begin
                  if (sts.is_full) status_in = lpst_pkg::ST_FULL;
                  else begin
                     cmd.wr_insert = 1'b1;
                     cmd.cnt_inc = 1'b1;
                     status_in = lpst_pkg::ST_INSERTED;
                     slot_in = probe10;
                  end
               end else status_in = lpst_pkg::ST_NOT_FOUND;
            end else if (sts.probe_wrap) begin
               if (sts.action == lpst_pkg::ACT_DELETE)
                  status_in = lpst_pkg::ST_DEL_MISSING;
               else if (sts.action == lpst_pkg::ACT_INSERT)
                  status_in = lpst_pkg::ST_FULL;
               else status_in = lpst_pkg::ST_NOT_FOUND;
            end else begin
               cmd.adv_probe = 1'b1;
               state_in = S_PRD;
            end
         end
         S_DCLR: begin
            cmd.wr_hole_clr = 1'b1;
            walk_in = '0;
            state_in = S_SRD;
         end
         S_SRD: begin
            cmd.rd_scan = 1'b1;
            walk_in = walk_ff + 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            // A walk that comes all the way round ends the shift with the hole left empty.
            if (!sts.rd_used || sts.scan_wrap) state_in = S_RESP;
            else if (sts.rd_movable) begin
               cmd.wr_move = 1'b1;
               state_in = S_DCLR;
            end else if (walk_ff == '0) state_in = S_RESP;
            else state_in = S_SRD;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      slot_ff <= slot_in;
      walk_ff <= walk_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_slot_index = slot_ff;

   `include "assert_macros.svh"
   `ASSERT_CLK(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `ASSERT_CLK(a_slot_zero, clock, reset,
      rsp_valid |-> (rsp_status == lpst_pkg::ST_FOUND ||
      rsp_status == lpst_pkg::ST_INSERTED || rsp_slot_index == 10'd0), "slot not zero")
   `ASSERT_CLK(a_accept_idle, clock, reset, (req_valid && req_ready) |=> state_ff == S_PRD,
      "accept did not start probe")
endmodule

[hdl/linear_probe_symbol_table.sv]
// Steps: accept, then a read and a check per probed slot; a delete then clears the hole and reads
// and checks each scanned slot, moving entries into the hole. One request at a time: accept, probe,
// check, result, handoff. Reset: synchronous, active high; a clearing pass then runs, during which
// no request is accepted.
// Top level: joins controller and datapath; uses lpst_pkg and lpst_chan_if.
module linear_probe_symbol_table #(
   parameter int TABLE_SLOTS = lpst_pkg::TableSlots,
   parameter int NAME_BYTES = lpst_pkg::NameBytes
) (
   input logic clock,
   input logic reset,
   lpst_chan_if.sink req,
   lpst_chan_if.source rsp
);
   localparam int AW = $clog2(TABLE_SLOTS);
   lpst_pkg::cmd_type cmd;
   lpst_pkg::sts_type sts;
   logic [AW-1:0] probe_slot;

   lpst_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .NAME_BYTES(NAME_BYTES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_action(req.data.action), .req_name_key(req.data.name_key),
      .probe_slot
   );

   lpst_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(rsp.data.status), .rsp_slot_index(rsp.data.slot_index),
      .probe_slot, .sts, .cmd
   );
endmodule
